// ===== hdl/hcrs_pkg.sv =====
// ----------------------------------------------------------------------------
// hcrs_pkg - height colour ramp shader shared definitions
// Fixed-point formats, palette band tables, reciprocals and pipeline structs.
// ----------------------------------------------------------------------------
package hcrs_pkg;

	localparam int HEIGHT_FRAC_BITS = 14;
	localparam int LIGHT_FRAC_BITS  = 8;

	localparam int HEIGHT_W   = 16;
	localparam int LIGHT_W    = 9;
	localparam int COLOR_W    = 8;
	localparam int MAG_W      = HEIGHT_W - 1;
	localparam int EDGE_W     = (HEIGHT_FRAC_BITS + 1 > MAG_W) ? HEIGHT_FRAC_BITS + 1 : MAG_W;
	localparam int NPAL       = 2;
	localparam int NBANDS     = 6;
	localparam int BAND_IDX_W = 3;
	localparam int RECIP_W    = 33;
	localparam int PROD_W     = MAG_W + RECIP_W;
	localparam int FRAC_SHIFT = 16;
	localparam int FRAC_W     = FRAC_SHIFT + 1;
	localparam int ACC_W      = COLOR_W + FRAC_SHIFT + 4;
	localparam int SHADE_W    = COLOR_W + LIGHT_W;

	localparam logic [COLOR_W-1:0] GREY_LEVEL = 8'd192;
	localparam logic [COLOR_W-1:0] COLOR_MAX  = 8'd255;
	localparam logic [FRAC_W-1:0]  FRAC_ONE   = 17'h10000;

	typedef logic [EDGE_W-1:0]             edge_t;
	typedef logic [RECIP_W-1:0]            recip_t;
	typedef logic [0:2][COLOR_W-1:0]       rgb_t;
	typedef logic [BAND_IDX_W-1:0]         band_idx_t;

	// thousandths to height units, rounded to nearest
	function automatic longint unsigned edge_of(input longint unsigned pm);
		return ((pm << HEIGHT_FRAC_BITS) + 500) / 1000;
	endfunction

	localparam longint unsigned E_000  = edge_of(0);
	localparam longint unsigned E_510  = edge_of(510);
	localparam longint unsigned E_530  = edge_of(530);
	localparam longint unsigned E_600  = edge_of(600);
	localparam longint unsigned E_750  = edge_of(750);
	localparam longint unsigned E_850  = edge_of(850);
	localparam longint unsigned E_900  = edge_of(900);
	localparam longint unsigned E_1000 = edge_of(1000);

	localparam longint unsigned SPAN_L0 = E_510 - E_000;
	localparam longint unsigned SPAN_L1 = E_530 - E_510;
	localparam longint unsigned SPAN_L2 = E_600 - E_530;
	localparam longint unsigned SPAN_L3 = E_850 - E_600;
	localparam longint unsigned SPAN_L4 = E_900 - E_850;
	localparam longint unsigned SPAN_L5 = E_1000 - E_900;
	localparam longint unsigned SPAN_I0 = E_510 - E_000;
	localparam longint unsigned SPAN_I1 = E_600 - E_510;
	localparam longint unsigned SPAN_I2 = E_750 - E_600;
	localparam longint unsigned SPAN_I3 = E_900 - E_750;
	localparam longint unsigned SPAN_I4 = E_1000 - E_900;
	localparam longint unsigned RECIP_ONE = 64'd1 << 32;

	localparam band_idx_t BAND_COUNT [NPAL] = '{3'd6, 3'd5};

	localparam edge_t LO_EDGE [NPAL][NBANDS] = '{
		'{edge_t'(E_000), edge_t'(E_510), edge_t'(E_530),
		  edge_t'(E_600), edge_t'(E_850), edge_t'(E_900)},
		'{edge_t'(E_000), edge_t'(E_510), edge_t'(E_600),
		  edge_t'(E_750), edge_t'(E_900), edge_t'(0)}
	};

	localparam edge_t HI_EDGE [NPAL][NBANDS] = '{
		'{edge_t'(E_510), edge_t'(E_530), edge_t'(E_600),
		  edge_t'(E_850), edge_t'(E_900), edge_t'(E_1000)},
		'{edge_t'(E_510), edge_t'(E_600), edge_t'(E_750),
		  edge_t'(E_900), edge_t'(E_1000), edge_t'(0)}
	};

	localparam recip_t RECIP [NPAL][NBANDS] = '{
		'{recip_t'((RECIP_ONE + SPAN_L0 / 2) / SPAN_L0),
		  recip_t'((RECIP_ONE + SPAN_L1 / 2) / SPAN_L1),
		  recip_t'((RECIP_ONE + SPAN_L2 / 2) / SPAN_L2),
		  recip_t'((RECIP_ONE + SPAN_L3 / 2) / SPAN_L3),
		  recip_t'((RECIP_ONE + SPAN_L4 / 2) / SPAN_L4),
		  recip_t'((RECIP_ONE + SPAN_L5 / 2) / SPAN_L5)},
		'{recip_t'((RECIP_ONE + SPAN_I0 / 2) / SPAN_I0),
		  recip_t'((RECIP_ONE + SPAN_I1 / 2) / SPAN_I1),
		  recip_t'((RECIP_ONE + SPAN_I2 / 2) / SPAN_I2),
		  recip_t'((RECIP_ONE + SPAN_I3 / 2) / SPAN_I3),
		  recip_t'((RECIP_ONE + SPAN_I4 / 2) / SPAN_I4),
		  recip_t'(0)}
	};

	localparam rgb_t LO_COLOR [NPAL][NBANDS] = '{
		'{'{8'd0, 8'd0, 8'd255}, '{8'd220, 8'd212, 8'd156}, '{8'd34, 8'd139, 8'd34},
		  '{8'd0, 8'd102, 8'd51}, '{8'd210, 8'd180, 8'd140}, '{8'd224, 8'd224, 8'd224}},
		'{'{8'd181, 8'd211, 8'd255}, '{8'd0, 8'd102, 8'd51}, '{8'd32, 8'd32, 8'd32},
		  '{8'd224, 8'd224, 8'd224}, '{8'd255, 8'd255, 8'd255}, '{8'd0, 8'd0, 8'd0}}
	};

	localparam rgb_t HI_COLOR [NPAL][NBANDS] = '{
		'{'{8'd0, 8'd0, 8'd255}, '{8'd34, 8'd139, 8'd34}, '{8'd0, 8'd102, 8'd51},
		  '{8'd210, 8'd180, 8'd140}, '{8'd224, 8'd224, 8'd224}, '{8'd224, 8'd224, 8'd224}},
		'{'{8'd181, 8'd211, 8'd255}, '{8'd32, 8'd32, 8'd32}, '{8'd224, 8'd224, 8'd224},
		  '{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd255, 8'd255}, '{8'd0, 8'd0, 8'd0}}
	};

	typedef struct packed {
		logic               valid;
		logic               neg;
		logic               found;
		logic               sel;
		band_idx_t          idx;
		logic [MAG_W-1:0]   offs;
		logic [LIGHT_W-1:0] light;
	} s1_t;

	typedef struct packed {
		logic               valid;
		logic               neg;
		logic               found;
		logic               sel;
		band_idx_t          idx;
		logic [PROD_W-1:0]  prod;
		logic [LIGHT_W-1:0] light;
	} s2_t;

	typedef struct packed {
		logic               valid;
		logic               neg;
		logic [LIGHT_W-1:0] light;
		rgb_t               chan;
	} s3_t;

	typedef struct packed {
		logic valid;
		rgb_t rgb;
	} s4_t;

	typedef struct packed {
		logic load_s2;
		logic load_s3;
	} lerp_ld_t;

endpackage

// ===== hdl/height_color_ramp_shader.sv =====
// ----------------------------------------------------------------------------
// height_color_ramp_shader - elevation to shaded pixel colour
// Four-stage pipeline: band search, reciprocal multiply, blend, shade.
// ----------------------------------------------------------------------------
// usage
// s_axis carries one pixel per beat: elevation (signed, 1.0 = 2^14) and a
// light level (1.0 = 256). m_axis returns one rgb beat per input beat, in
// order. cfg_we/cfg_wdata write the palette select (0 land, 1 ice); write it
// only while no beats are in flight.
// an accepted input beat passes through four register stages (band search,
// reciprocal multiply, colour blend, shading multiply) on its way to m_axis.
// throughput is one beat per cycle while m_axis_tready is high.
// each stage loads when it is empty or the stage after it moves, so bubbles
// are squeezed out under stall and s_axis_tready stays high while there is
// room; with m_axis_tready low and all four stages full, s_axis_tready drops
// and the held result stays on m_axis.
// reset empties the pipeline and selects the land palette.
// ----------------------------------------------------------------------------
module height_color_ramp_shader (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // height_level [15:0], light_level [24:16]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // red [7:0], green [15:8], blue [23:16]
);

	logic               palette_q;
	logic               load_s1;
	logic               load_s4;
	hcrs_pkg::lerp_ld_t lerp_ld;
	hcrs_pkg::s1_t      s1;
	hcrs_pkg::s2_t      s2;
	hcrs_pkg::s3_t      s3;
	hcrs_pkg::s4_t      s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_q <= 1'b0;
		end else if (cfg_we) begin
			palette_q <= cfg_wdata;
		end
	end

	// a stage loads when empty or when its successor is loading
	always_comb begin
		load_s4         = !s4.valid || m_axis_tready;
		lerp_ld.load_s3 = !s3.valid || load_s4;
		lerp_ld.load_s2 = !s2.valid || lerp_ld.load_s3;
		load_s1         = !s1.valid || lerp_ld.load_s2;
	end

	assign s_axis_tready = load_s1;

	hcrs_band_stage u_band (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load_s1),
		.in_valid (s_axis_tvalid),
		.height   (s_axis_tdata[15:0]),
		.light    (s_axis_tdata[24:16]),
		.sel      (palette_q),
		.s1       (s1)
	);

	hcrs_lerp_stage u_lerp (
		.clk    (clk),
		.arst_n (arst_n),
		.ld     (lerp_ld),
		.s1     (s1),
		.s2     (s2),
		.s3     (s3)
	);

	hcrs_shade_stage u_shade (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load_s4),
		.s3     (s3),
		.s4     (s4)
	);

	assign m_axis_tvalid = s4.valid;
	assign m_axis_tdata  = {s4.rgb[2], s4.rgb[1], s4.rgb[0]};

`ifndef ASSERT_OFF
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output is being taken");

	a_result_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !$past(m_axis_tvalid) |-> $past(s3.valid))
		else $error("result appeared without a beat in the blend stage");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("pipeline lost a beat under stall");
`endif

endmodule

// ===== hdl/hcrs_band_stage.sv =====
// ----------------------------------------------------------------------------
// hcrs_band_stage - band search
// Finds the palette band holding the elevation and its offset into the band.
// ----------------------------------------------------------------------------
module hcrs_band_stage (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            load,
	input  logic                            in_valid,
	input  logic [hcrs_pkg::HEIGHT_W-1:0]   height,
	input  logic [hcrs_pkg::LIGHT_W-1:0]    light,
	input  logic                            sel,
	output hcrs_pkg::s1_t                   s1
);

	logic               hit;
	hcrs_pkg::band_idx_t idx;
	hcrs_pkg::edge_t    lo;
	hcrs_pkg::edge_t    h_ext;

	always_comb begin
		h_ext = hcrs_pkg::edge_t'(height[hcrs_pkg::MAG_W-1:0]);
		hit   = 1'b0;
		idx   = '0;
		lo    = '0;
		// walk downwards so the lowest matching band wins
		for (int i = hcrs_pkg::NBANDS - 1; i >= 0; i--) begin
			if (hcrs_pkg::BAND_IDX_W'(i) < hcrs_pkg::BAND_COUNT[sel] &&
			    hcrs_pkg::HI_EDGE[sel][i] > hcrs_pkg::LO_EDGE[sel][i] &&
			    h_ext >= hcrs_pkg::LO_EDGE[sel][i] &&
			    h_ext <  hcrs_pkg::HI_EDGE[sel][i]) begin
				hit = 1'b1;
				idx = hcrs_pkg::BAND_IDX_W'(i);
				lo  = hcrs_pkg::LO_EDGE[sel][i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1 <= '0;
		end else if (load) begin
			s1.valid <= in_valid;
			s1.neg   <= height[hcrs_pkg::HEIGHT_W-1];
			s1.found <= hit;
			s1.sel   <= sel;
			s1.idx   <= idx;
			s1.offs  <= hcrs_pkg::MAG_W'(h_ext - lo);
			s1.light <= light;
		end
	end

`ifndef ASSERT_OFF
	a_band_in_palette: assert property (@(posedge clk) disable iff (!arst_n)
		s1.valid && s1.found |-> s1.idx < hcrs_pkg::BAND_COUNT[s1.sel])
		else $error("band index beyond palette");
`endif

endmodule

// ===== hdl/hcrs_lerp_stage.sv =====
// ----------------------------------------------------------------------------
// hcrs_lerp_stage - band fraction and colour interpolation
// Scales the band offset by the reciprocal, then blends the band end colours.
// ----------------------------------------------------------------------------
module hcrs_lerp_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  hcrs_pkg::lerp_ld_t  ld,
	input  hcrs_pkg::s1_t       s1,
	output hcrs_pkg::s2_t       s2,
	output hcrs_pkg::s3_t       s3
);

	logic [hcrs_pkg::PROD_W-hcrs_pkg::FRAC_SHIFT-1:0] frac_full;
	logic [hcrs_pkg::FRAC_W-1:0]                      frac;
	logic signed [hcrs_pkg::FRAC_W:0]                 frac_s;
	logic signed [hcrs_pkg::COLOR_W:0]                delta [3];
	logic signed [hcrs_pkg::ACC_W-1:0]                acc [3];
	hcrs_pkg::rgb_t                                   lc;
	hcrs_pkg::rgb_t                                   hc;
	hcrs_pkg::rgb_t                                   chan;

	// stage 2: offset times reciprocal
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2 <= '0;
		end else if (ld.load_s2) begin
			s2.valid <= s1.valid;
			s2.neg   <= s1.neg;
			s2.found <= s1.found;
			s2.sel   <= s1.sel;
			s2.idx   <= s1.idx;
			s2.light <= s1.light;
			s2.prod  <= hcrs_pkg::PROD_W'(s1.offs * hcrs_pkg::RECIP[s1.sel][s1.idx]);
		end
	end

	// stage 3: blend per channel
	always_comb begin
		frac_full = s2.prod[hcrs_pkg::PROD_W-1:hcrs_pkg::FRAC_SHIFT];
		if (frac_full > (hcrs_pkg::PROD_W-hcrs_pkg::FRAC_SHIFT)'(hcrs_pkg::FRAC_ONE)) begin
			frac = hcrs_pkg::FRAC_ONE;
		end else begin
			frac = frac_full[hcrs_pkg::FRAC_W-1:0];
		end
		frac_s = signed'({1'b0, frac});
		lc     = hcrs_pkg::LO_COLOR[s2.sel][s2.idx];
		hc     = hcrs_pkg::HI_COLOR[s2.sel][s2.idx];
		for (int k = 0; k < 3; k++) begin
			delta[k] = signed'({1'b0, hc[k]}) - signed'({1'b0, lc[k]});
			acc[k]   = signed'(hcrs_pkg::ACC_W'({lc[k], hcrs_pkg::FRAC_SHIFT'(0)})) +
			           hcrs_pkg::ACC_W'(delta[k] * frac_s);
			if (!s2.found) begin
				chan[k] = hcrs_pkg::GREY_LEVEL;
			end else if (acc[k][hcrs_pkg::ACC_W-1]) begin
				chan[k] = '0;
			end else if (|acc[k][hcrs_pkg::ACC_W-2:hcrs_pkg::FRAC_SHIFT+hcrs_pkg::COLOR_W]) begin
				chan[k] = hcrs_pkg::COLOR_MAX;
			end else begin
				chan[k] = acc[k][hcrs_pkg::FRAC_SHIFT +: hcrs_pkg::COLOR_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3 <= '0;
		end else if (ld.load_s3) begin
			s3.valid <= s2.valid;
			s3.neg   <= s2.neg;
			s3.light <= s2.light;
			s3.chan  <= chan;
		end
	end

endmodule

// ===== hdl/hcrs_shade_stage.sv =====
// ----------------------------------------------------------------------------
// hcrs_shade_stage - light scaling and output register
// Multiplies each channel by the light level and saturates; negative heights give grey.
// ----------------------------------------------------------------------------
module hcrs_shade_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  hcrs_pkg::s3_t  s3,
	output hcrs_pkg::s4_t  s4
);

	logic [hcrs_pkg::SHADE_W-1:0] prod [3];
	logic [hcrs_pkg::SHADE_W-1:0] lit [3];
	hcrs_pkg::rgb_t               rgb;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			prod[k] = hcrs_pkg::SHADE_W'(s3.chan[k] * s3.light);
			lit[k]  = prod[k] >> hcrs_pkg::LIGHT_FRAC_BITS;
			// negative heights bypass shading
			if (s3.neg) begin
				rgb[k] = hcrs_pkg::GREY_LEVEL;
			end else if (lit[k] > hcrs_pkg::SHADE_W'(hcrs_pkg::COLOR_MAX)) begin
				rgb[k] = hcrs_pkg::COLOR_MAX;
			end else begin
				rgb[k] = lit[k][hcrs_pkg::COLOR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s4 <= '0;
		end else if (load) begin
			s4.valid <= s3.valid;
			s4.rgb   <= rgb;
		end
	end

endmodule

// ===== test/shaded_pixel_checker.sv =====
// ----------------------------------------------------------------------------
// shaded_pixel_checker - result checker for the height colour ramp shader
// Watches the input, output and palette write ports, works out the shaded
// colour of every accepted pixel and compares each output beat against the
// oldest pending colour, channel by channel.
// ----------------------------------------------------------------------------
module shaded_pixel_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // height_level [15:0], light_level [24:16]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,  // red [7:0], green [15:8], blue [23:16]
	output int          error_count,
	output int          results_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         HEIGHT_FRAC  = 14;
	localparam int         LIGHT_FRAC   = 8;
	localparam int         LAND_BANDS   = 6;
	localparam int         ICE_BANDS    = 5;
	localparam logic [7:0] GREY         = 8'd192;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	// band edges in thousandths of full height, end colours as r, g, b
	typedef struct packed {
		logic [9:0]      lo_pm;
		logic [9:0]      hi_pm;
		logic [0:2][7:0] lo_c;
		logic [0:2][7:0] hi_c;
	} ramp_band_t;

	pixel_t colour_q[$];
	logic   palette_ice;
	int     fails     = 0;
	int     pending_n = 0;

	assign error_count     = fails;
	assign results_pending = pending_n;

	function automatic ramp_band_t ramp_band(input logic ice, input int idx);
		ramp_band_t b;
		b = '0;
		if (!ice) begin
			case (idx)
				0: b = {10'd0,   10'd510,  8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd255};
				1: b = {10'd510, 10'd530,  8'd220, 8'd212, 8'd156, 8'd34,  8'd139, 8'd34};
				2: b = {10'd530, 10'd600,  8'd34,  8'd139, 8'd34,  8'd0,   8'd102, 8'd51};
				3: b = {10'd600, 10'd850,  8'd0,   8'd102, 8'd51,  8'd210, 8'd180, 8'd140};
				4: b = {10'd850, 10'd900,  8'd210, 8'd180, 8'd140, 8'd224, 8'd224, 8'd224};
				5: b = {10'd900, 10'd1000, 8'd224, 8'd224, 8'd224, 8'd224, 8'd224, 8'd224};
				default: b = '0;
			endcase
		end else begin
			case (idx)
				0: b = {10'd0,   10'd510,  8'd181, 8'd211, 8'd255, 8'd181, 8'd211, 8'd255};
				1: b = {10'd510, 10'd600,  8'd0,   8'd102, 8'd51,  8'd32,  8'd32,  8'd32};
				2: b = {10'd600, 10'd750,  8'd32,  8'd32,  8'd32,  8'd224, 8'd224, 8'd224};
				3: b = {10'd750, 10'd900,  8'd224, 8'd224, 8'd224, 8'd255, 8'd255, 8'd255};
				4: b = {10'd900, 10'd1000, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
				default: b = '0;
			endcase
		end
		return b;
	endfunction

	// thousandths to height units, rounded to nearest
	function automatic longint unsigned pm_to_height(input longint unsigned pm);
		return ((pm << HEIGHT_FRAC) + 500) / 1000;
	endfunction

	function automatic pixel_t shade_height(input logic [15:0] height, input logic [8:0] light,
			input logic ice);
		pixel_t          px;
		ramp_band_t      b;
		logic [7:0]      chan [3];
		longint unsigned lo, hi, span, recip, frac;
		longint          acc;
		int unsigned     prod;
		int              nb;
		bit              hit;
		chan = '{GREY, GREY, GREY};
		hit  = 1'b0;
		// below sea level: plain grey, no shading
		if (height[15]) begin
			px.red   = GREY;
			px.green = GREY;
			px.blue  = GREY;
			return px;
		end
		nb = ice ? ICE_BANDS : LAND_BANDS;
		for (int i = 0; i < nb; i++) begin
			b  = ramp_band(ice, i);
			lo = pm_to_height(b.lo_pm);
			hi = pm_to_height(b.hi_pm);
			if (!hit && hi > lo && height >= lo && height < hi) begin
				hit   = 1'b1;
				span  = hi - lo;
				recip = ((64'd1 << 32) + span / 2) / span;
				frac  = ((height - lo) * recip) >> 16;
				if (frac > 65536)
					frac = 65536;
				for (int k = 0; k < 3; k++) begin
					acc = longint'(b.lo_c[k]) * 65536
						+ (longint'(b.hi_c[k]) - longint'(b.lo_c[k])) * longint'(frac);
					if (acc < 0)
						chan[k] = 8'd0;
					else if ((acc >>> 16) > 255)
						chan[k] = 8'd255;
					else
						chan[k] = acc[23:16];
				end
			end
		end
		// no band at or above full height: grey, but still shaded
		for (int k = 0; k < 3; k++) begin
			prod = chan[k] * light;
			prod = prod >> LIGHT_FRAC;
			if (prod > 255)
				prod = 255;
			chan[k] = prod[7:0];
		end
		px.red   = chan[0];
		px.green = chan[1];
		px.blue  = chan[2];
		return px;
	endfunction

	task automatic check_channel(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			fails++;
			$error("%s: expected %0d, actual %0d", name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_t want, got;
		if (!arst_n) begin
			palette_ice = 1'b0;
			colour_q.delete();
			pending_n = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.red   = m_axis_tdata[7:0];
				got.green = m_axis_tdata[15:8];
				got.blue  = m_axis_tdata[23:16];
				if (colour_q.size() == 0) begin
					fails++;
					$error("unexpected result beat: rgb %0d %0d %0d",
						got.red, got.green, got.blue);
				end else begin
					want = colour_q.pop_front();
					check_channel("red", want.red, got.red);
					check_channel("green", want.green, got.green);
					check_channel("blue", want.blue, got.blue);
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				colour_q.push_back(shade_height(s_axis_tdata[15:0], s_axis_tdata[24:16],
					palette_ice));
			if (cfg_we)
				palette_ice = cfg_wdata;
			pending_n = colour_q.size();
		end
	end

endmodule

// ===== test/tb_height_color_ramp_shader.sv =====
// ----------------------------------------------------------------------------
// tb_height_color_ramp_shader - testbench for the height colour ramp shader
// Drives band edges, sea level, full height and light extremes on both
// palettes, then random pixels under several idle and stall mixes; the
// checker beside the block predicts every colour and counts mismatches.
// ----------------------------------------------------------------------------
module tb_height_color_ramp_shader;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic PALETTE_LAND  = 1'b0;
	localparam logic PALETTE_ICE   = 1'b1;
	localparam int   RANDOM_PHASES = 8;
	localparam int   PHASE_BEATS   = 116;
	localparam int   FLUSH_CYCLES  = 6;
	localparam int   N_DIRECTED    = 13;

	// band boundaries of both palettes in height units
	localparam logic [15:0] RAMP_EDGES [8] = '{
		16'd0, 16'd8356, 16'd8684, 16'd9830, 16'd12288, 16'd13926, 16'd14746, 16'd16384
	};

	localparam logic [15:0] DIRECTED_HEIGHTS [N_DIRECTED] = '{
		16'h0000, 16'd8355, 16'd8356, 16'd8684, 16'd9830, 16'd12288, 16'd13926,
		16'd14745, 16'd16383, 16'd16384, 16'h7FFF, 16'h8000, 16'hFFFF
	};

	localparam logic [8:0] DIRECTED_LIGHTS [N_DIRECTED] = '{
		9'd256, 9'd256, 9'd128, 9'd255, 9'd0, 9'd511, 9'd1,
		9'd256, 9'd300, 9'd256, 9'd511, 9'd511, 9'd0
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;  // height_level [15:0], light_level [24:16]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;  // red [7:0], green [15:8], blue [23:16]

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int error_count;
	int results_pending;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	height_color_ramp_shader u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	shaded_pixel_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.error_count     (error_count),
		.results_pending (results_pending)
	);

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// all tasks are entered and left on a falling edge
	task automatic send_pixel(input logic [15:0] height, input logic [8:0] light);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, light, height};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (results_pending != 0)
			@(negedge clk);
		repeat (FLUSH_CYCLES) @(negedge clk);
	endtask

	task automatic write_palette(input logic ice);
		cfg_we    <= 1'b1;
		cfg_wdata <= ice;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [15:0] pick_height();
		int r;
		r = $urandom_range(99);
		if (r < 50)
			return 16'($urandom_range(16383));
		else if (r < 72)
			return 16'(int'(RAMP_EDGES[$urandom_range(7)]) + int'($urandom_range(6)) - 3);
		else if (r < 84)
			return 16'h8000 | 16'($urandom_range(16'h7FFF));
		else if (r < 94)
			return 16'($urandom_range(32767, 16384));
		return 16'($urandom_range(16'hFFFF));
	endfunction

	function automatic logic [8:0] pick_light();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return 9'd256;
		else if (r < 18)
			return 9'd0;
		else if (r < 28)
			return 9'($urandom_range(511, 257));
		return 9'($urandom_range(256));
	endfunction

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: band edges, sea level, full height, light extremes, both palettes
		write_palette(PALETTE_LAND);
		for (int i = 0; i < N_DIRECTED; i++)
			send_pixel(DIRECTED_HEIGHTS[i], DIRECTED_LIGHTS[i]);
		wait_drained();
		write_palette(PALETTE_ICE);
		for (int i = 0; i < N_DIRECTED; i++)
			send_pixel(DIRECTED_HEIGHTS[i], DIRECTED_LIGHTS[i]);
		wait_drained();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
				default: begin send_idle_pct = 26; recv_stall_pct = 26; end
			endcase
			write_palette((ph < RANDOM_PHASES / 2) ? PALETTE_LAND : PALETTE_ICE);
			for (int i = 0; i < PHASE_BEATS; i++) begin
				// now and then let the pipeline run dry before the next beat
				if ($urandom_range(99) == 0)
					wait_drained();
				send_pixel(pick_height(), pick_light());
			end
			wait_drained();
		end

		repeat (FLUSH_CYCLES) @(negedge clk);
		if (error_count == 0 && results_pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
